FILE: sv/urp_pkg.sv
// Package for the unicode-range token parser.
// Holds the beat types, the parse phase codes, character constants and the hex decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package urp_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [63:0] range_start;
        logic [63:0] range_end;
        logic [15:0] consumed;
    } result_t;

    typedef enum logic [1:0] {
        PH_START,
        PH_QMARK,
        PH_END,
        PH_DONE
    } phase_t;

    localparam logic [7:0]  CH_QMARK     = 8'h3F;
    localparam logic [7:0]  CH_DASH      = 8'h2D;
    localparam logic [3:0]  NIBBLE_F     = 4'hF;
    localparam logic [15:0] CONSUMED_MAX = 16'hFFFF;

    // Returns {is_hex, value}; value is zero when the byte is not a hex digit.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h41 + 8'd10)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h61 + 8'd10)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/unicode_range_parser.sv
// Unicode-range token parser: one byte per beat, one result beat per token.
// A byte accepted into the input register is parsed by the combinational step; the result register takes the result.
// Throughput: one byte per cycle, since the parse step between the input register and the
// result register is combinational; stalls only while a result beat is held by result_stall.
// Reset (rst_n, asynchronous, active low) empties both registers and clears the parse state.
// Depends on urp_pkg and urp_step.
`timescale 1ns / 1ps
`default_nettype none

module unicode_range_parser #(
    parameter int MAX_HEX_DIGITS = 6,
    parameter int COUNT_BITS     = 16
) (
    input  var logic              clk,
    input  var logic              rst_n,
    input  var logic              item_valid,
    output logic                  item_stall,
    input  var urp_pkg::item_t    item,
    output logic                  result_valid,
    input  var logic              result_stall,
    output urp_pkg::result_t      result
);
    import urp_pkg::*;

    localparam int DW = $clog2(MAX_HEX_DIGITS + 1);

    logic                  in_valid_reg;
    item_t                 in_data_reg;
    logic                  res_valid_reg;
    result_t               res_data_reg;

    phase_t                phase_reg;
    logic [63:0]           start_reg;
    logic [63:0]           end_reg;
    logic [DW - 1:0]       digit_reg;
    logic [COUNT_BITS-1:0] count_reg;

    phase_t                phase_next;
    logic [63:0]           start_next;
    logic [63:0]           end_next;
    logic [DW - 1:0]       digit_next;
    logic [COUNT_BITS-1:0] count_next;
    result_t               step_result;

    logic                  advance;

    // The pipeline moves unless a finished result is waiting on the far side.
    assign advance    = !(res_valid_reg && result_stall);
    assign item_stall = in_valid_reg && !advance;

    urp_step #(
        .MAX_HEX_DIGITS (MAX_HEX_DIGITS),
        .COUNT_BITS     (COUNT_BITS)
    ) u_step (
        .phase       (phase_reg),
        .start_acc   (start_reg),
        .end_acc     (end_reg),
        .digit_count (digit_reg),
        .char_count  (count_reg),
        .item        (in_data_reg),
        .phase_next  (phase_next),
        .start_next  (start_next),
        .end_next    (end_next),
        .digit_next  (digit_next),
        .count_next  (count_next),
        .result      (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            phase_reg     <= PH_START;
            start_reg     <= 64'd0;
            end_reg       <= 64'd0;
            digit_reg     <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (!in_valid_reg || advance)
            begin
                in_valid_reg <= item_valid;
            end
            if (advance)
            begin
                res_valid_reg <= in_valid_reg && in_data_reg.last;
                if (in_valid_reg)
                begin
                    phase_reg <= phase_next;
                    start_reg <= start_next;
                    end_reg   <= end_next;
                    digit_reg <= digit_next;
                    count_reg <= count_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_valid_reg || advance)
        begin
            in_data_reg <= item;
        end
        if (advance && in_valid_reg && in_data_reg.last)
        begin
            res_data_reg <= step_result;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_data_reg;

endmodule

`default_nettype wire

FILE: sv/urp_step.sv
// One parse step of the unicode-range parser: next state and result for one byte.
// Purely combinational; depends on urp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module urp_step #(
    parameter int MAX_HEX_DIGITS = 6,
    parameter int COUNT_BITS     = 16
) (
    input  var urp_pkg::phase_t                             phase,
    input  var logic [63:0]                                 start_acc,
    input  var logic [63:0]                                 end_acc,
    input  var logic [$clog2(MAX_HEX_DIGITS + 1) - 1:0]     digit_count,
    input  var logic [COUNT_BITS - 1:0]                     char_count,
    input  var urp_pkg::item_t                              item,
    output urp_pkg::phase_t                                 phase_next,
    output logic [63:0]                                     start_next,
    output logic [63:0]                                     end_next,
    output logic [$clog2(MAX_HEX_DIGITS + 1) - 1:0]         digit_next,
    output logic [COUNT_BITS - 1:0]                         count_next,
    output urp_pkg::result_t                                result
);
    import urp_pkg::*;

    localparam int DW = $clog2(MAX_HEX_DIGITS + 1);
    localparam logic [DW - 1:0] DIGIT_LIMIT = DW'(MAX_HEX_DIGITS);

    logic [4:0]            hex;
    logic                  is_hex;
    logic                  room;
    logic                  bump;
    phase_t                ph;
    logic [63:0]           s_acc;
    logic [63:0]           e_acc;
    logic [DW - 1:0]       d_cnt;
    logic [COUNT_BITS-1:0] c_cnt;
    logic [31:0]           count_wide;

    assign hex    = hex_decode(item.ch);
    assign is_hex = hex[4];
    assign room   = digit_count < DIGIT_LIMIT;

    always_comb
    begin
        ph    = phase;
        s_acc = start_acc;
        e_acc = end_acc;
        d_cnt = digit_count;
        bump  = 1'b0;
        case (phase)
            PH_START:
            begin
                if (is_hex && room)
                begin
                    s_acc = {start_acc[59:0], hex[3:0]};
                    d_cnt = digit_count + DW'(1);
                    bump  = 1'b1;
                end
                else if (item.ch == CH_QMARK)
                begin
                    s_acc = {start_acc[59:0], 4'h0};
                    e_acc = {start_acc[59:0], NIBBLE_F};
                    bump  = 1'b1;
                    ph    = PH_QMARK;
                end
                else if (item.ch == CH_DASH)
                begin
                    e_acc = 64'd0;
                    d_cnt = '0;
                    bump  = 1'b1;
                    ph    = PH_END;
                end
                else
                begin
                    e_acc = 64'd0;
                    ph    = PH_DONE;
                end
            end
            PH_QMARK:
            begin
                if (item.ch == CH_QMARK)
                begin
                    s_acc = {start_acc[59:0], 4'h0};
                    e_acc = {end_acc[59:0], NIBBLE_F};
                    bump  = 1'b1;
                end
                else
                begin
                    ph = PH_DONE;
                end
            end
            PH_END:
            begin
                if (is_hex && room)
                begin
                    e_acc = {end_acc[59:0], hex[3:0]};
                    d_cnt = digit_count + DW'(1);
                    bump  = 1'b1;
                end
                else
                begin
                    ph = PH_DONE;
                end
            end
            default:
            begin
                ph = phase;
            end
        endcase
    end

    // The byte counter sticks at all ones.
    assign c_cnt = (bump && char_count != '1) ? char_count + COUNT_BITS'(1) : char_count;
    assign count_wide = 32'(c_cnt);

    assign result.range_start = s_acc;
    assign result.range_end   = (ph == PH_START) ? 64'd0 : e_acc;
    assign result.consumed    = (count_wide > 32'(CONSUMED_MAX)) ? CONSUMED_MAX
                                                                 : count_wide[15:0];

    // The final byte of a token returns the parser to its initial state.
    always_comb
    begin
        if (item.last)
        begin
            phase_next = PH_START;
            start_next = 64'd0;
            end_next   = 64'd0;
            digit_next = '0;
            count_next = '0;
        end
        else
        begin
            phase_next = ph;
            start_next = s_acc;
            end_next   = e_acc;
            digit_next = d_cnt;
            count_next = c_cnt;
        end
    end

endmodule

`default_nettype wire
